// ===== sv/pdtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtc_pkg
// Shared types and constants for the PWM duty to temperature converter.
// ----------------------------------------------------------------------------
package pdtc_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int REG_W          = 16;
  localparam int NUM_BP         = 6;
  localparam int Q_DEPTH        = 2;

  // divider: dividend holds 5000*65535 + 32767, divisor one 16-bit register
  localparam int DIV_NW = 29;
  localparam int DIV_DW = 16;

  localparam int T_STEP = 1000;
  localparam int T_MIN  = -2000;
  localparam int T_MAX  = 12000;
  localparam int V_FULL = 5000;

  localparam int TEMP_W = 15;
  localparam int VOLT_W = 13;
  localparam int SEG_W  = 3;

  localparam logic [REG_W-1:0] WIN_RST = 16'd40000;

  typedef logic [NUM_BP-1:0][REG_W-1:0] bp_arr_t;

  localparam bp_arr_t BP_RST = {16'd11312, 16'd20964, 16'd28817,
                                16'd35015, 16'd39705, 16'd43133};

  typedef enum logic [2:0] {
    REG_WINDOW    = 3'd0,
    REG_BREAK_10C = 3'd1,
    REG_BREAK_20C = 3'd2,
    REG_BREAK_30C = 3'd3,
    REG_BREAK_40C = 3'd4,
    REG_BREAK_50C = 3'd5,
    REG_BREAK_60C = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SEG,
    B_LOAD_T,
    B_WAIT_T,
    B_LOAD_V,
    B_WAIT_V,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic              push;
    logic [REG_W-1:0]  count;
  } win_push_t;

  typedef struct packed {
    logic              valid;
    logic [REG_W-1:0]  count;
  } win_head_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/pdtc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtc_front
// Sample counter: counts samples and high samples, closes a window and
// pushes its high count into the queue.
// ----------------------------------------------------------------------------
module pdtc_front
  import pdtc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_pin_level,
  input  logic                  q_full,
  input  logic [COUNT_BITS-1:0] win_eff,
  output win_push_t             push
);

  logic [COUNT_BITS-1:0] sc_r, sc_nxt;
  logic [COUNT_BITS-1:0] hc_r, hc_nxt;
  logic [COUNT_BITS-1:0] sc_inc, hc_inc;
  logic                  accept;
  logic                  close;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign sc_inc   = sc_r + 1'b1;
  assign hc_inc   = hc_r + COUNT_BITS'(in_pin_level);
  assign close    = (sc_inc >= win_eff);

  always_comb begin
    sc_nxt     = sc_r;
    hc_nxt     = hc_r;
    push.push  = accept && close;
    // high count never exceeds the window, which fits 16 bits
    push.count = REG_W'(hc_inc);
    if (accept) begin
      if (close) begin
        sc_nxt = '0;
        hc_nxt = '0;
      end else begin
        sc_nxt = sc_inc;
        hc_nxt = hc_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= '0;
      hc_r <= '0;
    end else begin
      sc_r <= sc_nxt;
      hc_r <= hc_nxt;
    end
  end

endmodule

// ===== sv/pdtc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtc_queue
// Short queue of finished window counts between counter and converter.
// ----------------------------------------------------------------------------
module pdtc_queue
  import pdtc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  win_push_t push,
  input  logic      pop,
  output logic      full,
  output win_head_t head
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [REG_W-1:0] mem_r [Q_DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.count = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push.push) begin
      wp_nxt = (wp_r == PW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    case ({push.push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      mem_r[wp_r] <= push.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.push |-> !full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(Q_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== sv/pdtc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdtc_div
  import pdtc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_NW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dvs_r, dvs_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign rem_sh = {rem_r, quo_r[DIV_NW-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DIV_NW - 1);
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      // dividend shifts out at the top while quotient bits shift in
      rem_nxt = ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
      quo_nxt = {quo_r[DIV_NW-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("done without a run");
`endif

endmodule

// ===== sv/pdtc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtc_back
// Converter: picks the segment, runs temperature and voltage divisions on
// the shared divider, saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module pdtc_back
  import pdtc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  win_head_t                head,
  output logic                     pop,
  input  bp_arr_t                  bp,
  input  logic [REG_W-1:0]         win16,
  output div_req_t                 div_req,
  input  div_rsp_t                 div_rsp,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] out_temperature_centi,
  output logic [VOLT_W-1:0]        out_voltage_mv,
  output logic [SEG_W-1:0]         out_segment
);

  localparam int TW = DIV_NW + 2;

  back_state_t state_r, state_nxt;

  logic [REG_W-1:0]         h_r, h_nxt;
  logic [SEG_W-1:0]         k_r, k_nxt;
  logic [REG_W-1:0]         mag_r, mag_nxt;
  logic [REG_W-1:0]         ud_r, ud_nxt;
  logic                     neg_r, neg_nxt;
  logic                     dz_r, dz_nxt;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic [VOLT_W-1:0]        volt_r, volt_nxt;
  div_req_t                 req_r, req_nxt;

  logic                     ov_r, ov_nxt;
  logic signed [TEMP_W-1:0] ot_r, ot_nxt;
  logic [VOLT_W-1:0]        ovm_r, ovm_nxt;
  logic [SEG_W-1:0]         os_r, os_nxt;

  logic [REG_W-1:0]         bx [NUM_BP+1];
  logic [SEG_W-1:0]         k_sel;
  logic [REG_W:0]           ndiff, ddiff, nneg, dneg;
  logic signed [TW-1:0]     base, q, tw;

  assign out_valid             = ov_r;
  assign out_temperature_centi = ot_r;
  assign out_voltage_mv        = ovm_r;
  assign out_segment           = os_r;
  assign div_req               = req_r;

  always_comb begin
    for (int i = 0; i < NUM_BP; i++) begin
      bx[i] = bp[i];
    end
    bx[NUM_BP] = '0;   // 70 degrees at zero count
    // first segment whose lower breakpoint the count reaches
    k_sel = SEG_W'(NUM_BP - 1);
    for (int i = NUM_BP - 2; i >= 0; i--) begin
      if (h_r >= bx[i+1]) k_sel = SEG_W'(i);
    end
    ndiff = {1'b0, bx[k_sel]} - {1'b0, h_r};
    ddiff = {1'b0, bx[k_sel]} - {1'b0, bx[k_sel + 1'b1]};
    nneg  = -ndiff;
    dneg  = -ddiff;
  end

  always_comb begin
    base = TW'(T_STEP * (int'(k_r) + 1));
    q    = signed'({2'b00, div_rsp.quotient});
    if (dz_r)       tw = base;
    else if (neg_r) tw = base - q;
    else            tw = base + q;
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    h_nxt     = h_r;
    k_nxt     = k_r;
    mag_nxt   = mag_r;
    ud_nxt    = ud_r;
    neg_nxt   = neg_r;
    dz_nxt    = dz_r;
    temp_nxt  = temp_r;
    volt_nxt  = volt_r;
    req_nxt   = req_r;
    req_nxt.start = 1'b0;
    ov_nxt    = ov_r && out_stall;
    ot_nxt    = ot_r;
    ovm_nxt   = ovm_r;
    os_nxt    = os_r;

    case (state_r)
      B_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          h_nxt     = head.count;
          state_nxt = B_SEG;
        end
      end
      B_SEG: begin
        k_nxt     = k_sel;
        mag_nxt   = ndiff[REG_W] ? nneg[REG_W-1:0] : ndiff[REG_W-1:0];
        ud_nxt    = ddiff[REG_W] ? dneg[REG_W-1:0] : ddiff[REG_W-1:0];
        neg_nxt   = ndiff[REG_W] ^ ddiff[REG_W];
        dz_nxt    = (ddiff == '0);
        state_nxt = B_LOAD_T;
      end
      B_LOAD_T: begin
        // rounding: add half the divisor, ties go away from zero
        req_nxt.start    = 1'b1;
        req_nxt.dividend = DIV_NW'(mag_r) * DIV_NW'(T_STEP) + DIV_NW'(ud_r >> 1);
        req_nxt.divisor  = ud_r;
        state_nxt        = B_WAIT_T;
      end
      B_WAIT_T: begin
        if (div_rsp.done) begin
          if (tw < TW'(T_MIN))      temp_nxt = TEMP_W'(T_MIN);
          else if (tw > TW'(T_MAX)) temp_nxt = TEMP_W'(T_MAX);
          else                      temp_nxt = TEMP_W'(tw);
          state_nxt = B_LOAD_V;
        end
      end
      B_LOAD_V: begin
        req_nxt.start    = 1'b1;
        req_nxt.dividend = DIV_NW'(h_r) * DIV_NW'(V_FULL) + DIV_NW'(win16 >> 1);
        req_nxt.divisor  = win16;
        state_nxt        = B_WAIT_V;
      end
      B_WAIT_V: begin
        if (div_rsp.done) begin
          volt_nxt  = (div_rsp.quotient > DIV_NW'(V_FULL)) ? VOLT_W'(V_FULL)
                                                            : div_rsp.quotient[VOLT_W-1:0];
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ot_nxt    = temp_r;
          ovm_nxt   = volt_r;
          os_nxt    = k_r;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      ov_r        <= 1'b0;
      req_r.start <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ov_r        <= ov_nxt;
      req_r.start <= req_nxt.start;
    end
  end

  always_ff @(posedge clk) begin
    h_r              <= h_nxt;
    k_r              <= k_nxt;
    mag_r            <= mag_nxt;
    ud_r             <= ud_nxt;
    neg_r            <= neg_nxt;
    dz_r             <= dz_nxt;
    temp_r           <= temp_nxt;
    volt_r           <= volt_nxt;
    req_r.dividend   <= req_nxt.dividend;
    req_r.divisor    <= req_nxt.divisor;
    ot_r             <= ot_nxt;
    ovm_r            <= ovm_nxt;
    os_r             <= os_nxt;
  end

endmodule

// ===== sv/pwm_duty_temperature_converter_top.sv =====
`timescale 1ns / 1ps
// Path: the count of a closed window goes through the queue, the segment pick,
//   two runs of the shared divider and the output register, which out_stall holds.
// Throughput: one sample per cycle while the two-entry window queue has room;
//   the converter takes one window at a time and waits in B_DONE while the output is held.
// Reset: synchronous, active low; counters and queue empty, registers to defaults.
// ----------------------------------------------------------------------------
// pwm_duty_temperature_converter_top
// Counts high PWM samples per window and converts the count to voltage and
// a piecewise linear temperature.
// ----------------------------------------------------------------------------
module pwm_duty_temperature_converter_top
  import pdtc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_pin_level,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] out_temperature_centi,
  output logic [VOLT_W-1:0]        out_voltage_mv,
  output logic [SEG_W-1:0]         out_segment,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [REG_W-1:0]         cfg_wdata
);

  localparam logic [32:0] CMAX = (33'd1 << COUNT_BITS) - 33'd1;

  logic [REG_W-1:0]      win_r, win_nxt;
  bp_arr_t               bp_r, bp_nxt;
  logic [32:0]           w33;
  logic [COUNT_BITS-1:0] win_eff;
  logic [REG_W-1:0]      win16;

  win_push_t push;
  win_head_t head;
  logic      q_full;
  logic      pop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign cfg_ready = 1'b1;

  always_comb begin
    win_nxt = win_r;
    bp_nxt  = bp_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_WINDOW:    win_nxt   = cfg_wdata;
        REG_BREAK_10C: bp_nxt[0] = cfg_wdata;
        REG_BREAK_20C: bp_nxt[1] = cfg_wdata;
        REG_BREAK_30C: bp_nxt[2] = cfg_wdata;
        REG_BREAK_40C: bp_nxt[3] = cfg_wdata;
        REG_BREAK_50C: bp_nxt[4] = cfg_wdata;
        REG_BREAK_60C: bp_nxt[5] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_RST;
      bp_r  <= BP_RST;
    end else begin
      win_r <= win_nxt;
      bp_r  <= bp_nxt;
    end
  end

  // zero window acts as one; window limited to what the counters hold
  always_comb begin
    w33     = (win_r == '0) ? 33'd1 : 33'(win_r);
    win_eff = COUNT_BITS'((w33 > CMAX) ? CMAX : w33);
    win16   = REG_W'(win_eff);
  end

  pdtc_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pin_level (in_pin_level),
    .q_full       (q_full),
    .win_eff      (win_eff),
    .push         (push)
  );

  pdtc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  pdtc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pdtc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head                  (head),
    .pop                   (pop),
    .bp                    (bp_r),
    .win16                 (win16),
    .div_req               (div_req),
    .div_rsp               (div_rsp),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_temperature_centi (out_temperature_centi),
    .out_voltage_mv        (out_voltage_mv),
    .out_segment           (out_segment)
  );

endmodule

// ===== dv/tb_pwm_duty_temperature_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pwm_duty_temperature_converter_top
// Self-checking bench for the PWM duty to temperature converter. Pin samples
// are streamed in under random idling and receiver back-pressure, registers
// are reprogrammed between phases, and every reading is compared field by
// field against an in-bench model of the window counter and the piecewise
// linear conversion.
// ----------------------------------------------------------------------------
module tb_pwm_duty_temperature_converter_top;
  import pdtc_pkg::*;

  localparam int          RESET_CYCLES    = 11;
  localparam int          IDLE_PCT        = 18;
  localparam int          SETTLE_CYCLES   = 100;
  localparam int          PRESSURE_CYCLES = 300;
  localparam int          RANDOM_ITEMS    = 950;
  localparam int          MAX_REPORTS     = 10;
  localparam logic [2:0]  REG_UNUSED      = 3'd7;

  typedef struct {
    logic signed [TEMP_W-1:0] temp_centi;
    logic [VOLT_W-1:0]        volt_mv;
    logic [SEG_W-1:0]         seg;
  } reading_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [15:0] data;
    logic        pin;
    bit          typed;
    int          exp_temp;
    int          exp_volt;
    int          exp_seg;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_pin_level = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [TEMP_W-1:0] out_temperature_centi;
  logic [VOLT_W-1:0]        out_voltage_mv;
  logic [SEG_W-1:0]         out_segment;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [2:0]               cfg_index = '0;
  logic [REG_W-1:0]         cfg_wdata = '0;

  // register shadow and window counters
  logic [REG_W-1:0] win_reg = WIN_RST;
  bp_arr_t          bp_reg = BP_RST;
  int unsigned      samples_seen = 0;
  int unsigned      highs_seen = 0;

  reading_t expected_readings[$];
  reading_t oldest_reading;
  reading_t no_reading = '{default: '0};
  int       mismatch_count = 0;
  int       rand_items = 0;
  bit       calm = 1'b0;
  bit       hold_req = 1'b0;
  int       hold_left = 0;

  pwm_duty_temperature_converter_top u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_pin_level          (in_pin_level),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_temperature_centi (out_temperature_centi),
    .out_voltage_mv        (out_voltage_mv),
    .out_segment           (out_segment),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint active_window();
    return (win_reg == '0) ? 1 : longint'(win_reg);
  endfunction

  // nearest integer, ties away from zero
  function automatic longint nearest_quotient(input longint n, input longint d);
    longint un, ud, q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q  = (un + ud / 2) / ud;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic reading_t window_reading(input longint h);
    longint   b [0:6];
    longint   t, d, v, w;
    int       k;
    reading_t r;
    for (int i = 0; i < NUM_BP; i++) b[i] = longint'(bp_reg[i]);
    b[6] = 0;
    k = 5;
    for (int i = 4; i >= 0; i--) if (h >= b[i+1]) k = i;
    t = (k + 1) * T_STEP;
    d = b[k] - b[k+1];
    if (d != 0) t += nearest_quotient(T_STEP * (b[k] - h), d);
    if (t < T_MIN) t = T_MIN;
    if (t > T_MAX) t = T_MAX;
    w = active_window();
    v = (V_FULL * h + w / 2) / w;
    if (v > V_FULL) v = V_FULL;
    r.temp_centi = t[TEMP_W-1:0];
    r.volt_mv    = v[VOLT_W-1:0];
    r.seg        = k[SEG_W-1:0];
    return r;
  endfunction

  function automatic bit count_sample(input logic pin, output reading_t r);
    samples_seen = (samples_seen + 1) & 32'hFFFF;
    if (pin) highs_seen = (highs_seen + 1) & 32'hFFFF;
    r = no_reading;
    if (samples_seen >= active_window()) begin
      r = window_reading(highs_seen);
      samples_seen = 0;
      highs_seen = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_sample(input logic pin, input bit typed, input reading_t typed_val);
    reading_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pin_level <= pin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (count_sample(pin, r)) expected_readings.push_back(typed ? typed_val : r);
  endtask

  // leaves cfg_valid high; caller lowers it after the last write of a batch
  task automatic write_reg(input logic [2:0] idx, input logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_WINDOW) win_reg = val;
    else if (idx <= REG_BREAK_60C) bp_reg[idx - 3'd1] = val;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [REG_W-1:0] win, input bp_arr_t bps,
                               input bit poke_unused);
    settle();
    write_reg(REG_WINDOW, win);
    for (int i = 0; i < NUM_BP; i++) write_reg(3'(REG_BREAK_10C + i), bps[i]);
    if (poke_unused) write_reg(REG_UNUSED, REG_W'($urandom_range(16'hFFFF)));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int phase_no);
    int unsigned w, weff, top, n, density, pick;
    int unsigned bpq[$];
    bp_arr_t     bps;
    pick = $urandom_range(9);
    if (pick == 0)      w = $urandom_range(1);
    else if (pick <= 6) w = $urandom_range(16, 2);
    else if (pick <= 8) w = $urandom_range(64, 17);
    else                w = $urandom_range(300, 65);
    if (phase_no == 2) w = 1;
    weff = (w == 0) ? 1 : w;
    top  = weff + weff / 4 + 1;

    // mostly descending breakpoints scaled to the window, plus odd shapes
    pick = $urandom_range(9);
    for (int i = 0; i < NUM_BP; i++) begin
      if (pick <= 5 || pick == 8) bpq.push_back($urandom_range(top));
      else if (pick == 6)         bpq.push_back($urandom_range(3) * top / 3);
      else if (pick == 7)         bpq.push_back($urandom_range(16'hFFFF));
      else                        bpq.push_back($urandom_range(1) ? 16'hFFFF : 0);
    end
    if (pick <= 6) bpq.rsort();
    else if (pick == 8) bpq.sort();
    for (int i = 0; i < NUM_BP; i++) bps[i] = REG_W'(bpq[i]);

    load_settings(REG_W'(w), bps, $urandom_range(3) == 0);

    n = weff * $urandom_range(4, 1) + $urandom_range(weff);
    if (n > 160) n = weff + $urandom_range(8);
    density = $urandom_range(100);
    calm = (phase_no >= 4 && phase_no <= 6);
    if (phase_no == 2) begin
      n = 40;
      hold_req = 1'b1;
    end
    repeat (n) send_sample($urandom_range(99) < density, 1'b0, no_reading);
    calm = 1'b0;
    rand_items += n;
  endtask

  dir_row_t directed_rows [] = '{
    // zero window behaves as a one-sample window
    '{1, REG_WINDOW,    16'd0,     0, 0, 0, 0, 0},
    '{0, REG_WINDOW,    16'd0,     0, 1, 7000, 0, 5},
    '{0, REG_WINDOW,    16'd0,     1, 1, 7000, 5000, 5},
    // unmapped index must not disturb anything
    '{1, REG_UNUSED,    16'hFFFF,  0, 0, 0, 0, 0},
    '{0, REG_WINDOW,    16'd0,     1, 1, 7000, 5000, 5},
    // all breakpoints equal: slope term drops out
    '{1, REG_BREAK_10C, 16'd0,     0, 0, 0, 0, 0},
    '{1, REG_BREAK_20C, 16'd0,     0, 0, 0, 0, 0},
    '{1, REG_BREAK_30C, 16'd0,     0, 0, 0, 0, 0},
    '{1, REG_BREAK_40C, 16'd0,     0, 0, 0, 0, 0},
    '{1, REG_BREAK_50C, 16'd0,     0, 0, 0, 0, 0},
    '{1, REG_BREAK_60C, 16'd0,     0, 0, 0, 0, 0},
    '{0, REG_WINDOW,    16'd0,     0, 1, 1000, 0, 0},
    '{0, REG_WINDOW,    16'd0,     1, 1, 1000, 5000, 0},
    '{1, REG_BREAK_10C, 16'hFFFF,  0, 0, 0, 0, 0},
    '{1, REG_BREAK_20C, 16'hFFFF,  0, 0, 0, 0, 0},
    '{1, REG_BREAK_30C, 16'hFFFF,  0, 0, 0, 0, 0},
    '{1, REG_BREAK_40C, 16'hFFFF,  0, 0, 0, 0, 0},
    '{1, REG_BREAK_50C, 16'hFFFF,  0, 0, 0, 0, 0},
    '{1, REG_BREAK_60C, 16'hFFFF,  0, 0, 0, 0, 0},
    '{0, REG_WINDOW,    16'd0,     0, 1, 7000, 0, 5},
    '{0, REG_WINDOW,    16'd0,     1, 1, 7000, 5000, 5},
    // breakpoints out of order
    '{1, REG_BREAK_10C, 16'd1,     0, 0, 0, 0, 0},
    '{1, REG_BREAK_20C, 16'd0,     0, 0, 0, 0, 0},
    '{0, REG_WINDOW,    16'd0,     0, 1, 2000, 0, 0},
    '{0, REG_WINDOW,    16'd0,     1, 1, 1000, 5000, 0},
    '{1, REG_WINDOW,    16'd2,     0, 0, 0, 0, 0},
    '{0, REG_WINDOW,    16'd0,     1, 0, 0, 0, 0},
    '{0, REG_WINDOW,    16'd0,     0, 1, 1000, 2500, 0},
    '{0, REG_WINDOW,    16'd0,     1, 0, 0, 0, 0},
    '{0, REG_WINDOW,    16'd0,     1, 1, 0, 5000, 0},
    // half-way temperature rounds away from zero
    '{1, REG_BREAK_10C, 16'd2000,  0, 0, 0, 0, 0},
    '{0, REG_WINDOW,    16'd0,     1, 0, 0, 0, 0},
    '{0, REG_WINDOW,    16'd0,     0, 1, 2000, 2500, 0}
  };

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = PRESSURE_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected reading temp=%0d volt=%0d seg=%0d", $realtime,
                   out_temperature_centi, out_voltage_mv, out_segment);
      end else begin
        oldest_reading = expected_readings.pop_front();
        if (out_temperature_centi !== oldest_reading.temp_centi ||
            out_voltage_mv !== oldest_reading.volt_mv ||
            out_segment !== oldest_reading.seg) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: reading mismatch exp temp=%0d volt=%0d seg=%0d, got temp=%0d volt=%0d seg=%0d",
                     $realtime, oldest_reading.temp_centi, oldest_reading.volt_mv,
                     oldest_reading.seg, out_temperature_centi, out_voltage_mv, out_segment);
        end
      end
    end
  end

  initial begin
    reading_t typed_val;
    int       phase_no;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (i == 0 || !directed_rows[i-1].is_cfg) settle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
        if (i == directed_rows.size() - 1 || !directed_rows[i+1].is_cfg) cfg_valid <= 1'b0;
      end else begin
        typed_val.temp_centi = TEMP_W'(directed_rows[i].exp_temp);
        typed_val.volt_mv    = VOLT_W'(directed_rows[i].exp_volt);
        typed_val.seg        = SEG_W'(directed_rows[i].exp_seg);
        send_sample(directed_rows[i].pin, directed_rows[i].typed, typed_val);
      end
    end

    phase_no = 0;
    while (rand_items < RANDOM_ITEMS) begin
      run_random_phase(phase_no);
      phase_no++;
    end

    // close any partial window
    load_settings(16'd1, BP_RST, 1'b0);
    send_sample(1'b0, 1'b0, no_reading);

    settle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
